// ===== src/gray_world_white_balance_assert.svh =====
// Assertion macros for the gray-world white balance block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef GRAY_WORLD_WHITE_BALANCE_ASSERT_SVH
`define GRAY_WORLD_WHITE_BALANCE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define GWWB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define GWWB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gwwb_pkg.sv =====
// Shared constants, channel codes and controller/datapath interface structs
// for the gray-world white balance block. No dependencies.
package gwwb_pkg;

  localparam int PIXEL_COUNT_BITS_DEF = 22;
  localparam int GAIN_FRAC_BITS_DEF   = 16;

  localparam logic       CMD_STAT = 1'b0;
  localparam logic       CMD_CORR = 1'b1;
  localparam logic [7:0] PIX_MAX  = 8'd255;

  typedef enum logic [1:0] {
    CH_BLUE,
    CH_GREEN,
    CH_RED
  } chan_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  acc;        // add accepted statistics beat into sums
    logic  corr;       // launch accepted correction beat
    logic  total_ld;   // latch the sum of all three channel sums
    logic  div_load;   // set up divider for chan
    logic  div_check;  // flag quotient overflow
    logic  div_step;   // one restoring division step
    logic  gain_wr;    // write finished gain for chan
    logic  sum_clr;    // clear the channel sums
    chan_t chan;
  } gwwb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_free;   // correction stage can take a beat
    logic p_valid;     // product stage holds a beat
  } gwwb_stat_t;

endpackage

// ===== src/gwwb_dp.sv =====
// Datapath: channel sums, shared one-bit-per-cycle gain divider, gain
// registers and the two-stage correction pipe. Depends on gwwb_pkg.
module gwwb_dp import gwwb_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF,
  parameter int GAIN_FRAC_BITS   = GAIN_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  gwwb_cmd_t  cmd,
  output gwwb_stat_t stat,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_green,
  input  logic [7:0] in_red,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_blue,
  output logic [7:0] out_green,
  output logic [7:0] out_red,
  output logic       out_last
);

  localparam int SUM_W  = 8 + PIXEL_COUNT_BITS;
  localparam int GAIN_W = 8 + GAIN_FRAC_BITS;
  localparam int DIV_W  = SUM_W + 2;
  localparam int PROD_W = 8 + GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_SAT   = {GAIN_W{1'b1}};

  logic [SUM_W-1:0]  sum_b_r, sum_g_r, sum_r_r;
  logic [GAIN_W-1:0] gain_b_r, gain_g_r, gain_r_r;
  logic [DIV_W-1:0]  total_r;
  logic [DIV_W-1:0]  d_r, rem_r, rem_nxt;
  logic [GAIN_W-1:0] quo_r, gain_nxt;
  logic              zero_r, ovf_r;
  logic [SUM_W-1:0]  sel_sum;
  logic [DIV_W:0]    rem_sh;
  logic              q_bit;

  logic [PROD_W-1:0] p_b_r, p_g_r, p_r_r;
  logic              p_last_r, p_valid_r;
  logic              out_valid_r, out_last_r;
  logic [7:0]        out_b_r, out_g_r, out_r_r;
  logic              move;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                              input logic [7:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W + 1)'(v);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [7:0] clip(input logic [PROD_W-1:0] p);
    return (|p[GAIN_FRAC_BITS+8 +: 8]) ? PIX_MAX : p[GAIN_FRAC_BITS +: 8];
  endfunction

  always_comb begin
    case (cmd.chan)
      CH_BLUE:  sel_sum = sum_b_r;
      CH_GREEN: sel_sum = sum_g_r;
      CH_RED:   sel_sum = sum_r_r;
      default:  sel_sum = sum_r_r;
    endcase
  end

  // Restoring step: shift next dividend bit into remainder, subtract if it fits
  assign rem_sh  = {rem_r, quo_r[GAIN_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, d_r});
  assign rem_nxt = q_bit ? DIV_W'(rem_sh - {1'b0, d_r}) : rem_sh[DIV_W-1:0];

  assign gain_nxt = zero_r ? '0 : (ovf_r ? GAIN_SAT : quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_b_r  <= '0;
      sum_g_r  <= '0;
      sum_r_r  <= '0;
      gain_b_r <= GAIN_UNITY;
      gain_g_r <= GAIN_UNITY;
      gain_r_r <= GAIN_UNITY;
    end else begin
      if (cmd.acc) begin
        sum_b_r <= sat_add(sum_b_r, in_blue);
        sum_g_r <= sat_add(sum_g_r, in_green);
        sum_r_r <= sat_add(sum_r_r, in_red);
      end else if (cmd.sum_clr) begin
        sum_b_r <= '0;
        sum_g_r <= '0;
        sum_r_r <= '0;
      end
      if (cmd.gain_wr) begin
        case (cmd.chan)
          CH_BLUE:  gain_b_r <= gain_nxt;
          CH_GREEN: gain_g_r <= gain_nxt;
          CH_RED:   gain_r_r <= gain_nxt;
          default:  gain_r_r <= gain_nxt;
        endcase
      end
    end
  end

  // Divider: quotient of (total << frac) / (3 * sum), dividend split so the
  // high part seeds the remainder and the low bits shift in through quo_r
  always_ff @(posedge clk) begin
    if (cmd.total_ld) begin
      total_r <= DIV_W'(sum_b_r) + DIV_W'(sum_g_r) + DIV_W'(sum_r_r);
    end
    if (cmd.div_load) begin
      d_r    <= DIV_W'(sel_sum) + {DIV_W'(sel_sum) << 1};
      rem_r  <= total_r >> 8;
      quo_r  <= {total_r[7:0], {GAIN_FRAC_BITS{1'b0}}};
      zero_r <= (sel_sum == '0);
    end else if (cmd.div_check) begin
      ovf_r <= (rem_r >= d_r);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[GAIN_W-2:0], q_bit};
    end
  end

  // Correction pipe: products, then clipped output register
  assign move           = p_valid_r && (!out_valid_r || !out_stall);
  assign stat.pipe_free = !p_valid_r || move;
  assign stat.p_valid   = p_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.corr) begin
        p_valid_r <= 1'b1;
      end else if (move) begin
        p_valid_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.corr) begin
      p_b_r    <= PROD_W'(in_blue) * PROD_W'(gain_b_r);
      p_g_r    <= PROD_W'(in_green) * PROD_W'(gain_g_r);
      p_r_r    <= PROD_W'(in_red) * PROD_W'(gain_r_r);
      p_last_r <= in_last;
    end
    if (move) begin
      out_b_r    <= clip(p_b_r);
      out_g_r    <= clip(p_g_r);
      out_r_r    <= clip(p_r_r);
      out_last_r <= p_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_blue  = out_b_r;
  assign out_green = out_g_r;
  assign out_red   = out_r_r;
  assign out_last  = out_last_r;

endmodule

// ===== src/gwwb_ctrl.sv =====
// Controller: input handshake and the frame-end gain sequencer that walks
// the shared divider over the three channels. Depends on gwwb_pkg.
module gwwb_ctrl import gwwb_pkg::*; #(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_cmd,
  input  logic       in_last,
  output logic       in_stall,
  input  gwwb_stat_t stat,
  output gwwb_cmd_t  cmd
);

  localparam int GAIN_W = 8 + GAIN_FRAC_BITS;
  localparam int CNT_W  = $clog2(GAIN_W);

  typedef enum logic [2:0] {
    S_RUN,
    S_TOTAL,
    S_LOAD,
    S_CHECK,
    S_DIV,
    S_STORE
  } state_t;

  state_t           state_r, state_nxt;
  chan_t            chan_r, chan_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_stall = (state_r != S_RUN) || !stat.pipe_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd           = '0;
    cmd.chan      = chan_r;
    cmd.acc       = accept && (in_cmd == CMD_STAT);
    cmd.corr      = accept && (in_cmd == CMD_CORR);
    cmd.total_ld  = (state_r == S_TOTAL);
    cmd.div_load  = (state_r == S_LOAD);
    cmd.div_check = (state_r == S_CHECK);
    cmd.div_step  = (state_r == S_DIV);
    cmd.gain_wr   = (state_r == S_STORE);
    cmd.sum_clr   = (state_r == S_STORE) && (chan_r == CH_RED);
  end

  always_comb begin
    state_nxt = state_r;
    chan_nxt  = chan_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_RUN: begin
        if (cmd.acc && in_last) begin
          state_nxt = S_TOTAL;
        end
      end
      S_TOTAL: begin
        chan_nxt  = CH_BLUE;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(GAIN_W - 1)) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        case (chan_r)
          CH_BLUE: begin
            chan_nxt  = CH_GREEN;
            state_nxt = S_LOAD;
          end
          CH_GREEN: begin
            chan_nxt  = CH_RED;
            state_nxt = S_LOAD;
          end
          default: begin
            chan_nxt  = CH_BLUE;
            state_nxt = S_RUN;
          end
        endcase
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      chan_r  <= CH_BLUE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== src/gray_world_white_balance.sv =====
// Gray-world white balance, two passes per frame. Statistics beats (cmd 0)
// and correction beats (cmd 1) are taken one per clock while in_stall is
// low. The statistics beat marked last starts the gain update: the channel
// sums are totalled, then per channel a shared restoring divider is loaded,
// checked for quotient overflow, runs 8 + GAIN_FRAC_BITS steps and stores
// the gain; input stalls until all three gains are stored. A correction
// beat passes through the product register and then the clipped output
// register, held while out_stall backs up the output. Gains reset to unity.
// Depends on gwwb_pkg, gwwb_ctrl, gwwb_dp and the assertion macro header.
`include "gray_world_white_balance_assert.svh"

module gray_world_white_balance import gwwb_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF,
  parameter int GAIN_FRAC_BITS   = GAIN_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_blue_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_red_in,
  input  logic       in_last_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_blue_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_red_out,
  output logic       out_last_out
);

  gwwb_cmd_t  cmd;
  gwwb_stat_t stat;

  gwwb_ctrl #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_cmd  (in_cmd),
    .in_last (in_last_in),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  gwwb_dp #(
    .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS),
    .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_blue  (in_blue_in),
    .in_green (in_green_in),
    .in_red   (in_red_in),
    .in_last  (in_last_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_blue (out_blue_out),
    .out_green(out_green_out),
    .out_red  (out_red_out),
    .out_last (out_last_out)
  );

  `GWWB_ASSERT_NEXT(a_frame_end_busy, cmd.acc && in_last_in, in_stall, "no stall after frame end beat")
  `GWWB_ASSERT_NEXT(a_corr_launch, cmd.corr, stat.p_valid, "correction beat lost at product stage")
  `GWWB_ASSERT_IMPL(a_seq_onehot, 1'b1, $onehot0({cmd.total_ld, cmd.div_load, cmd.div_check, cmd.div_step, cmd.gain_wr}), "overlapping sequencer commands")
  `GWWB_ASSERT_IMPL(a_no_beat_in_div, cmd.div_step || cmd.gain_wr, !cmd.acc && !cmd.corr, "beat taken during gain update")

endmodule
